// ===== src/pli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg: palette lookup/insert shared types
// Colour width and the search token that walks the row of palette cells.
// ----------------------------------------------------------------------------
package pli_pkg;

	localparam int COLOR_W   = 24;  // {red, green, blue}
	localparam int TOK_IDX_W = 8;   // wide enough for the deepest palette (256)

	// Search token handed from cell to cell
	typedef struct packed {
		logic                 valid;  // token present in this slot
		logic [COLOR_W-1:0]   colour; // colour searched for
		logic                 done;   // matched or stored further up the row
		logic                 added;  // stored as a new entry
		logic [TOK_IDX_W-1:0] idx;    // index of match or new entry
	} tok_t;

endpackage : pli_pkg
`default_nettype wire

// ===== src/pli_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_cell: one palette entry
// Holds a colour, compares it with the passing token, stores the colour when
// it is the first free slot, and registers the token for the next cell.
// ----------------------------------------------------------------------------
module pli_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 8
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire [CNT_W-1:0]    entry_count,
	input  wire pli_pkg::tok_t tok_in,
	output pli_pkg::tok_t      tok_out
);
	import pli_pkg::*;

	logic [COLOR_W-1:0] entry_q;
	tok_t               tok_q;
	tok_t               tok_nxt;
	logic               live;
	logic               hit;
	logic               wr;

	// entries below entry_count are in use; the one at entry_count is free
	assign live = tok_in.valid && !tok_in.done;
	assign hit  = live && (CNT_W'(IDX) < entry_count) && (entry_q == tok_in.colour);
	assign wr   = live && (CNT_W'(IDX) == entry_count);

	always_comb begin
		tok_nxt = tok_in;
		if (hit) begin
			tok_nxt.done = 1'b1;
			tok_nxt.idx  = TOK_IDX_W'(IDX);
		end else if (wr) begin
			tok_nxt.done  = 1'b1;
			tok_nxt.added = 1'b1;
			tok_nxt.idx   = TOK_IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q <= tok_in.colour;
		end
	end

	assign tok_out = tok_q;

endmodule : pli_cell
`default_nettype wire

// ===== src/palette_lookup_insert_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_lookup_insert_top: colour palette lookup / append
// Lookup: token walks one palette cell per cycle, then pending and output regs.
//   A new item is accepted only once the last result is in the output register.
// Clear: skips the row; its result goes straight to the pending register.
// Reset (arst_n low, asynchronous): palette empty, no token in flight, no
//   result pending. Entry contents are left as they are; no clearing pass.
// ----------------------------------------------------------------------------
module palette_lookup_insert_top #(
	parameter int PALETTE_DEPTH = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  wire         s_tuser,   // req_type: 0 = look up / insert, 1 = clear
	// result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata    // color_index[6:0], was_added[7],
	                               // palette_full[8], entries_used[16:9],
	                               // zero[23:17]
);
	import pli_pkg::*;

	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	// request kinds on s_tuser
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// Control
	logic             busy_q;     // item accepted, result not yet in output reg
	logic             pend_q;     // result waiting for the output register
	logic             out_vld_q;
	logic [CNT_W-1:0] count_q;    // entries in use

	// Result payload
	logic [6:0]       pend_idx_q;
	logic             pend_add_q;
	logic             pend_full_q;
	logic [7:0]       pend_used_q;
	logic [23:0]      out_data_q;

	logic             in_acc;
	logic             out_go;
	logic [CNT_W-1:0] count_nxt;
	tok_t             tok_head;
	tok_t             tok_tail;

	// Row of cells: tok_chain[i] feeds cell i, tok_chain[PALETTE_DEPTH] is the tail
	tok_t tok_chain [PALETTE_DEPTH+1];

	assign s_tready = !busy_q;
	assign in_acc   = s_tvalid && s_tready;

	// only lookups enter the row; a clear is answered at once
	always_comb begin
		tok_head        = '0;
		tok_head.valid  = in_acc && (s_tuser == REQ_LOOKUP);
		tok_head.colour = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
	end

	assign tok_chain[0] = tok_head;

	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		pli_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.entry_count (count_q),
			.tok_in      (tok_chain[i]),
			.tok_out     (tok_chain[i+1])
		);
	end

	assign tok_tail  = tok_chain[PALETTE_DEPTH];
	// a token that left the row unresolved found neither a match nor a free slot
	assign count_nxt = count_q + CNT_W'(tok_tail.added);

	// pending result moves on when the output register is free or being emptied
	assign out_go = pend_q && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
			count_q   <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				if (s_tuser == REQ_CLEAR) begin
					pend_q  <= 1'b1;
					count_q <= '0;
				end
			end
			if (tok_tail.valid) begin
				pend_q  <= 1'b1;
				count_q <= count_nxt;
			end
			if (out_go) begin
				pend_q    <= 1'b0;
				busy_q    <= 1'b0;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == REQ_CLEAR)) begin
			pend_idx_q  <= '0;
			pend_add_q  <= 1'b0;
			pend_full_q <= 1'b0;
			pend_used_q <= '0;
		end
		if (tok_tail.valid) begin
			pend_idx_q  <= tok_tail.done ? tok_tail.idx[6:0] : 7'd0;
			pend_add_q  <= tok_tail.added;
			pend_full_q <= !tok_tail.done;
			pend_used_q <= 8'(count_nxt);
		end
		if (out_go) begin
			out_data_q <= {7'd0, pend_used_q, pend_full_q, pend_add_q, pend_idx_q};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule : palette_lookup_insert_top
`default_nettype wire

// ===== verif/palette_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_tb_pkg: request codes shared by the palette testbench files
// Kind of request carried on the input tuser bit.
// ----------------------------------------------------------------------------
package palette_tb_pkg;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,  // look up colour, append when new
		REQ_CLEAR  = 1'b1   // empty the palette
	} req_kind_e;

endpackage : palette_tb_pkg

// ===== verif/palette_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_checker: palette lookup/insert scoreboard
// Watches both streams, keeps its own palette to work out the answer to each
// accepted request and compares every returned item with the oldest answer due.
// ----------------------------------------------------------------------------
module palette_checker
	import pli_pkg::*;
	import palette_tb_pkg::*;
#(
	parameter int PALETTE_DEPTH = 128
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  wire        s_tuser,   // req_type
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [23:0] m_tdata,   // color_index[6:0], was_added[7],
	                              // palette_full[8], entries_used[16:9]
	output int         errors,
	output int         pending,
	output int         checked,
	output int         hits,
	output int         appends,
	output int         overflows,
	output int         clears
);

	typedef struct packed {
		logic [6:0] index;
		logic       added;
		logic       full;
		logic [7:0] used;
	} answer_t;

	logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
	int unsigned        used_cnt;
	answer_t            answers_due [$];

	function automatic answer_t resolve(input req_kind_e kind,
	                                    input logic [COLOR_W-1:0] colour);
		answer_t     a;
		bit          found;
		int unsigned slot;
		int unsigned k;
		a     = '0;
		found = 1'b0;
		slot  = 0;
		if (kind == REQ_CLEAR) begin
			used_cnt = 0;
			clears++;
		end else begin
			// lowest matching entry wins
			for (k = 0; k < used_cnt; k++) begin
				if (!found && palette[k] == colour) begin
					found = 1'b1;
					slot  = k;
				end
			end
			if (found) begin
				a.index = slot[6:0];
				hits++;
			end else if (used_cnt < PALETTE_DEPTH) begin
				palette[used_cnt] = colour;
				a.index  = used_cnt[6:0];
				a.added  = 1'b1;
				used_cnt = used_cnt + 1;
				appends++;
			end else begin
				a.full = 1'b1;
				overflows++;
			end
		end
		a.used = used_cnt[7:0];
		return a;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] palette_checker: %s", $time, msg);
	endtask

	task automatic check_answer(input logic [23:0] word);
		answer_t due;
		answer_t got;
		got = '{index: word[6:0], added: word[7], full: word[8], used: word[16:9]};
		if (answers_due.size() == 0) begin
			flag_error($sformatf("unexpected result item %h", word));
		end else begin
			due = answers_due.pop_front();
			checked++;
			if (got.index !== due.index || got.added !== due.added ||
			    got.full !== due.full || got.used !== due.used ||
			    word[23:17] !== 7'd0)
				flag_error($sformatf({"result %0d: index %0d/%0d added %0b/%0b ",
					"full %0b/%0b used %0d/%0d pad %h (expected/actual)"},
					checked, due.index, got.index, due.added, got.added,
					due.full, got.full, due.used, got.used, word[23:17]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_cnt = 0;
			answers_due.delete();
			pending = 0;
		end else begin
			// a result leaving now belongs to an earlier request
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				check_answer(m_tdata);
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				answers_due.push_back(resolve(req_kind_e'(s_tuser),
					{s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}));
			pending = answers_due.size();
		end
	end

endmodule : palette_checker

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: palette lookup/insert stream test
// Drives directed and random lookup/clear requests, fills the palette past
// capacity, varies idling on both sides and lets the checker judge each item.
// ----------------------------------------------------------------------------
module testbench;
	import palette_tb_pkg::*;

	localparam int PALETTE_DEPTH   = 128;
	localparam int CYCLE_LIMIT     = 1_000_000; // watchdog limit
	localparam int HOLD_OFF_CYCLES = 400;       // long receiver stall

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [23:0] m_tdata;

	int unsigned tx_idle_pct = 16;   // chance in 100 of a sender gap cycle
	int unsigned rx_idle_pct = 61;   // chance in 100 of receiver not ready
	bit          rx_hold_req = 1'b0; // asks the receiver for a long stall
	int          cycles      = 0;
	int          items_sent  = 0;
	logic [23:0] seen_colours [$];   // {r,g,b} sent since the last clear

	int errors, pending, checked, hits, appends, overflows, clears;

	always #1 clk = ~clk;

	palette_lookup_insert_top #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	palette_checker #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked),
		.hits     (hits),
		.appends  (appends),
		.overflows(overflows),
		.clears   (clears)
	);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** palette_lookup_insert_top: FAILED **");
			$finish;
		end
	end

	// Receiver side. Random back-pressure, plus one long hold-off counted
	// here, so the block sits on a finished result with a request waiting.
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// One request item; rgb is {red, green, blue}. Returns at the edge
	// that accepted it, so the next item can follow without a gap.
	task automatic send_item(input req_kind_e kind, input logic [23:0] rgb);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		items_sent++;
		if (kind == REQ_CLEAR)
			seen_colours.delete();
		else
			seen_colours.push_back(rgb);
	endtask

	// Random request: a clear, a repeat of a colour already sent (a hit
	// unless it was turned away when full), or a new colour. Half of the new
	// colours are one bit away from a stored one to stress the compare.
	task automatic send_random(input int unsigned clear_pct,
	                           input int unsigned reuse_pct);
		int unsigned roll;
		logic [23:0] rgb;
		roll = $urandom_range(99);
		rgb  = $urandom;
		if (roll < clear_pct) begin
			send_item(REQ_CLEAR, rgb);
		end else if (seen_colours.size() == 0) begin
			send_item(REQ_LOOKUP, rgb);
		end else if (roll < clear_pct + reuse_pct) begin
			send_item(REQ_LOOKUP,
				seen_colours[$urandom_range(seen_colours.size() - 1)]);
		end else if ($urandom_range(1) == 0) begin
			send_item(REQ_LOOKUP,
				seen_colours[$urandom_range(seen_colours.size() - 1)] ^
				(24'd1 << $urandom_range(23)));
		end else begin
			send_item(REQ_LOOKUP, rgb);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: channel extremes, hits on first and later slots,
		// near misses, clears with junk colour and on an empty palette.
		send_item(REQ_LOOKUP, 24'h000000); // appended at slot 0
		send_item(REQ_LOOKUP, 24'h000000); // hit slot 0
		send_item(REQ_LOOKUP, 24'hFFFFFF);
		send_item(REQ_LOOKUP, 24'hFF0000);
		send_item(REQ_LOOKUP, 24'h00FF00);
		send_item(REQ_LOOKUP, 24'h0000FF);
		send_item(REQ_LOOKUP, 24'hAA55AA);
		send_item(REQ_LOOKUP, 24'h55AA55);
		send_item(REQ_LOOKUP, 24'hFFFFFF); // hit slot 1
		send_item(REQ_LOOKUP, 24'h0000FF); // hit slot 4
		send_item(REQ_LOOKUP, 24'hFF00FF); // differs from slot 4 in red only
		send_item(REQ_LOOKUP, 24'h0000FE); // one bit off slot 4
		send_item(REQ_CLEAR,  24'hFFFFFF); // colour bits ignored
		send_item(REQ_LOOKUP, 24'hFFFFFF); // stale entries must not match
		send_item(REQ_CLEAR,  24'h000000);
		send_item(REQ_CLEAR,  24'h5A5A5A); // clear on an empty palette
		send_item(REQ_LOOKUP, 24'h123456);
		send_item(REQ_LOOKUP, 24'h123456);
		send_item(REQ_LOOKUP, 24'h654321);

		// Mixed traffic with occasional clears; slow receiver.
		repeat (150) send_random(3, 35);

		// Slow sender: fresh clear, then mostly new colours so the palette
		// fills, turns colours away, and still hits on stored ones.
		tx_idle_pct = 61;
		rx_idle_pct = 16;
		send_item(REQ_CLEAR, $urandom);
		repeat (170) send_random(0, 10);

		// No idling; the receiver stalls once for a long stretch.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b1;
		repeat (130) send_random(4, 40);
		s_tvalid <= 1'b0;

		// Drain, then keep watching for stray items.
		while (pending != 0) @(posedge clk);
		repeat (PALETTE_DEPTH + 4) @(posedge clk);

		$display("Run: %0d requests sent, %0d results checked in %0d cycles.",
			items_sent, checked, cycles);
		$display("Seen: %0d hits, %0d appends, %0d turned away when full, %0d clears.",
			hits, appends, overflows, clears);
		if (errors == 0 && pending == 0) begin
			$display("** palette_lookup_insert_top: PASSED **");
		end else begin
			$display("** palette_lookup_insert_top: FAILED **");
		end
		$finish;
	end

endmodule : testbench

// ===== palette_lookup_insert_top.f =====
src/pli_pkg.sv
src/pli_cell.sv
src/palette_lookup_insert_top.sv
verif/palette_tb_pkg.sv
verif/palette_checker.sv
verif/testbench.sv
